FILE: hw/rtl/knn4_pkg.sv
// knn4_pkg: shared types and constants for the four-feature knn classifier
// no dependencies; imported by every module of the block

package knn4_pkg;

  localparam int FEAT_COUNT = 4;   // features per sample
  localparam int NEIGHBOURS = 4;   // selection passes per query
  localparam int VOTERS     = 3;   // neighbours that take part in the vote
  localparam int LABEL_BITS = 2;
  localparam int COUNT_BITS = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [LABEL_BITS-1:0] CLASS_NONE = 2'd0;
  localparam logic [LABEL_BITS-1:0] CLASS_ONE  = 2'd1;
  localparam logic [LABEL_BITS-1:0] CLASS_TWO  = 2'd2;
  localparam logic [LABEL_BITS-1:0] CLASS_THREE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_NEXT,
    ST_VOTE
  } state_t;

endpackage

FILE: hw/rtl/knn4_store.sv
// knn4_store: single-port-write, registered-read sample memory
// depends on knn4_pkg (imported for house consistency of widths)

module knn4_store
  import knn4_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int WIDTH     = 34,
  parameter int ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/knn4_dist.sv
// knn4_dist: three-stage pipelined squared euclidean distance unit
// depends on knn4_pkg for the feature count

module knn4_dist
  import knn4_pkg::*;
#(
  parameter int FEATURE_BITS = 8,
  parameter int TAG_BITS     = 10,
  parameter int DIST_BITS    = 2 * FEATURE_BITS + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [FEATURE_BITS-1:0] sample_feat [FEAT_COUNT],
  input  logic [FEATURE_BITS-1:0] query_feat  [FEAT_COUNT],
  input  logic [TAG_BITS-1:0]     in_tag,
  output logic                    out_valid,
  output logic [DIST_BITS-1:0]    out_dist,
  output logic [TAG_BITS-1:0]     out_tag,
  output logic                    active
);

  logic [FEATURE_BITS-1:0]   diff [FEAT_COUNT];
  logic [2*FEATURE_BITS-1:0] sq   [FEAT_COUNT];
  logic [TAG_BITS-1:0]       tag1, tag2;
  logic                      vld1, vld2;
  logic [DIST_BITS-1:0]      sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  // stage 1: absolute differences
  always_ff @(posedge clk) begin
    for (int i = 0; i < FEAT_COUNT; i++) begin
      diff[i] <= (sample_feat[i] >= query_feat[i]) ? sample_feat[i] - query_feat[i]
                                                   : query_feat[i] - sample_feat[i];
    end
    tag1 <= in_tag;
  end

  // stage 2: squares, one small multiplier per feature lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < FEAT_COUNT; i++) begin
      sq[i] <= diff[i] * diff[i];
    end
    tag2 <= tag1;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < FEAT_COUNT; i++) begin
      sum = sum + DIST_BITS'(sq[i]);
    end
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    out_dist <= sum;
    out_tag  <= tag2;
  end

  assign active = vld1 | vld2 | out_valid;

endmodule

FILE: hw/rtl/knn_four_feature_classifier.sv
// knn_four_feature_classifier: k=3 nearest neighbour classifier, fourth-neighbour tie break
// depends on knn4_pkg, knn4_store and knn4_dist
//
// load transfer (mode 0): busy stays low, no result
// query transfer (mode 1): four selection passes stream the loaded samples from the sample memory
//   through the shared distance unit at one sample per cycle, each pass followed by a drain of
//   the read and distance pipeline, then a vote state; busy drops with done, so the next transfer
//   can be taken in the done cycle
// done strobes for one cycle only, results hold until the next vote; the receiver cannot stall
// rst (synchronous, active high) empties the store and clears the mismatch count

module knn_four_feature_classifier
  import knn4_pkg::*;
#(
  parameter int STORE_DEPTH  = 256,
  parameter int FEATURE_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode,
  input  logic [FEATURE_BITS-1:0] feature_a,
  input  logic [FEATURE_BITS-1:0] feature_b,
  input  logic [FEATURE_BITS-1:0] feature_c,
  input  logic [FEATURE_BITS-1:0] feature_d,
  input  logic [LABEL_BITS-1:0]   label,
  output logic                    done,
  output logic [LABEL_BITS-1:0]   predicted_class,
  output logic                    mismatch,
  output logic [COUNT_BITS-1:0]   error_count
);

  localparam int IDX_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(STORE_DEPTH + 1);
  localparam int ENTRY_BITS = FEAT_COUNT * FEATURE_BITS + LABEL_BITS;
  localparam int TAG_BITS   = IDX_BITS + LABEL_BITS;
  localparam int DIST_BITS  = 2 * FEATURE_BITS + 2;

  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(STORE_DEPTH);
  localparam logic [1:0]          LAST_PASS = 2'(NEIGHBOURS - 1);

  // sequencer
  state_t state, state_next;

  // control strobes from the sequencer
  logic accept, do_load, do_query, issue, pass_end, do_vote;

  // store and scan
  logic [CNT_BITS-1:0]   loaded_count;
  logic [CNT_BITS-1:0]   addr;
  logic                  rd_vld;
  logic [IDX_BITS-1:0]   rd_idx;
  logic [ENTRY_BITS-1:0] rdata;
  logic [ENTRY_BITS-1:0] wdata;

  // query registers
  logic [FEATURE_BITS-1:0] query_feat  [FEAT_COUNT];
  logic [FEATURE_BITS-1:0] sample_feat [FEAT_COUNT];
  logic [LABEL_BITS-1:0]   query_label;

  // distance unit outputs
  logic                 dist_vld;
  logic [DIST_BITS-1:0] scan_dist;
  logic [TAG_BITS-1:0]  dist_tag;
  logic                 dist_active;
  logic [IDX_BITS-1:0]  dist_idx;
  logic [LABEL_BITS-1:0] dist_label;

  // pass bookkeeping
  logic [1:0]            pass;
  logic                  best_found;
  logic [DIST_BITS-1:0]  best_dist;
  logic [IDX_BITS-1:0]   best_idx;
  logic [LABEL_BITS-1:0] best_label;
  logic [IDX_BITS-1:0]   pick_idx [VOTERS];
  logic                  pick_ok  [VOTERS];
  logic [LABEL_BITS-1:0] cls      [NEIGHBOURS];
  logic                  excluded;
  logic                  take;
  logic [LABEL_BITS-1:0] vote_class;

  // two-of-three majority, fourth neighbour breaks a three-way split
  function automatic logic [LABEL_BITS-1:0] vote(
    input logic [LABEL_BITS-1:0] c0,
    input logic [LABEL_BITS-1:0] c1,
    input logic [LABEL_BITS-1:0] c2,
    input logic [LABEL_BITS-1:0] c3
  );
    logic [1:0] n1, n2, n3;
    n1 = 2'(c0 == CLASS_ONE)   + 2'(c1 == CLASS_ONE)   + 2'(c2 == CLASS_ONE);
    n2 = 2'(c0 == CLASS_TWO)   + 2'(c1 == CLASS_TWO)   + 2'(c2 == CLASS_TWO);
    n3 = 2'(c0 == CLASS_THREE) + 2'(c1 == CLASS_THREE) + 2'(c2 == CLASS_THREE);
    if (n1 == 2'd1 && n2 == 2'd1 && n3 == 2'd1) return c3;
    if (n1 >= 2'd2) return CLASS_ONE;
    if (n2 >= 2'd2) return CLASS_TWO;
    if (n3 >= 2'd2) return CLASS_THREE;
    return CLASS_NONE;
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer strobes
  always_comb begin
    state_next = state;
    do_load    = 1'b0;
    do_query   = 1'b0;
    issue      = 1'b0;
    pass_end   = 1'b0;
    do_vote    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_QUERY) begin
            do_query   = 1'b1;
            state_next = ST_SCAN;
          end else begin
            do_load = (loaded_count < DEPTH_CNT);
          end
        end
      end
      ST_SCAN: begin
        // one sample address per cycle until the loaded count is reached
        if (addr != loaded_count) begin
          issue = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the read and the distance pipeline empty before closing the pass
        if (!rd_vld && !dist_active) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        pass_end   = 1'b1;
        state_next = (pass == LAST_PASS) ? ST_VOTE : ST_SCAN;
      end
      ST_VOTE: begin
        do_vote    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sample memory: label above the four features
  assign wdata = {label, feature_d, feature_c, feature_b, feature_a};

  knn4_store #(
    .DEPTH     (STORE_DEPTH),
    .WIDTH     (ENTRY_BITS),
    .ADDR_BITS (IDX_BITS)
  ) u_store (
    .clk   (clk),
    .we    (do_load),
    .waddr (loaded_count[IDX_BITS-1:0]),
    .wdata (wdata),
    .re    (issue),
    .raddr (addr[IDX_BITS-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    for (int i = 0; i < FEAT_COUNT; i++) begin
      sample_feat[i] = rdata[i*FEATURE_BITS +: FEATURE_BITS];
    end
  end

  knn4_dist #(
    .FEATURE_BITS (FEATURE_BITS),
    .TAG_BITS     (TAG_BITS),
    .DIST_BITS    (DIST_BITS)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (rd_vld),
    .sample_feat (sample_feat),
    .query_feat  (query_feat),
    .in_tag      ({rd_idx, rdata[ENTRY_BITS-1 -: LABEL_BITS]}),
    .out_valid   (dist_vld),
    .out_dist    (scan_dist),
    .out_tag     (dist_tag),
    .active      (dist_active)
  );

  assign dist_idx   = dist_tag[TAG_BITS-1 -: IDX_BITS];
  assign dist_label = dist_tag[LABEL_BITS-1:0];

  // skip samples picked by an earlier pass of this query
  always_comb begin
    excluded = 1'b0;
    for (int e = 0; e < VOTERS; e++) begin
      if ((2'(e) < pass) && pick_ok[e] && (pick_idx[e] == dist_idx)) begin
        excluded = 1'b1;
      end
    end
  end

  // strict less-than keeps the lowest index on equal distance
  assign take = dist_vld & ~excluded & (~best_found | (scan_dist < best_dist));

  assign vote_class = vote(cls[0], cls[1], cls[2], cls[3]);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      error_count  <= '0;
      done         <= 1'b0;
      rd_vld       <= 1'b0;
      best_found   <= 1'b0;
      pass         <= '0;
      addr         <= '0;
      for (int e = 0; e < VOTERS; e++) begin
        pick_ok[e] <= 1'b0;
      end
    end else begin
      done   <= do_vote;
      rd_vld <= issue;
      if (do_load) begin
        loaded_count <= loaded_count + 1'b1;
      end
      if (do_query) begin
        // exclusion list cleared per query
        pass       <= '0;
        addr       <= '0;
        best_found <= 1'b0;
        for (int e = 0; e < VOTERS; e++) begin
          pick_ok[e] <= 1'b0;
        end
      end
      if (issue) begin
        addr <= addr + 1'b1;
      end
      if (take) begin
        best_found <= 1'b1;
      end
      if (pass_end) begin
        if (pass != LAST_PASS) begin
          pick_ok[pass] <= best_found;
        end
        best_found <= 1'b0;
        addr       <= '0;
        pass       <= pass + 1'b1;
      end
      if (do_vote && (vote_class != query_label) && (error_count != COUNT_MAX)) begin
        error_count <= error_count + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (do_query) begin
      query_feat[0] <= feature_a;
      query_feat[1] <= feature_b;
      query_feat[2] <= feature_c;
      query_feat[3] <= feature_d;
      query_label   <= label;
    end
    if (issue) begin
      rd_idx <= addr[IDX_BITS-1:0];
    end
    if (take) begin
      best_dist  <= scan_dist;
      best_idx   <= dist_idx;
      best_label <= dist_label;
    end
    if (pass_end) begin
      // a missing neighbour counts as no class
      cls[pass] <= best_found ? best_label : CLASS_NONE;
      if (pass != LAST_PASS) begin
        pick_idx[pass] <= best_idx;
      end
    end
    if (do_vote) begin
      predicted_class <= vote_class;
      mismatch        <= (vote_class != query_label);
    end
  end

  // checks
  a_vote_strobes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VOTE) |=> done)
    else $error("result strobe missing after vote");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while sequencer busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= DEPTH_CNT)
    else $error("loaded count beyond store depth");

  a_err_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> error_count >= $past(error_count))
    else $error("mismatch count decreased");

endmodule
